>>> src/nrf_pkg.sv
// shared constants and types for the nonce result filter
package nrf_pkg;

  // default sizes
  localparam int MaxSlotsDef  = 8;
  localparam int MaxGoldenDef = 4;
  localparam int RingDepthDef = 64;

  // fixed field widths
  localparam int NonceW    = 32;
  localparam int SlotW     = 3;
  localparam int SlotsCfgW = 4;
  localparam int ExtraCfgW = 2;
  localparam int CfgDataW  = 4;
  localparam int CfgIdxW   = 2;
  localparam int GoldenPorts = 4;
  localparam int GoldenIdxW  = 2;
  localparam int GoldenCntW  = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegSlotsInUse    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegExtraSolution = 2'd1;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_HIST  = 6'b000010,
    S_NEXT  = 6'b000100,
    S_SCAN  = 6'b001000,
    S_STORE = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

>>> src/nonce_result_filter_top.sv
// nonce result filter: slot history check and ring based duplicate share filter
//
// Usage: an item (one slot report) is taken at a clock edge with start high
// and busy low. busy stays high until the last result word of the item has
// been driven. Results come one per cycle, each marked by done for exactly
// one cycle; last flags the final word of the item. The receiver cannot
// stall, so words are simply driven in order.
// Sequence: the slot history is read as the item is taken and is checked and
// written back in the next cycle; then, with a valid slot and hash_ok set,
// each enabled, nonzero golden nonce is looked for in the ring through its
// single read port, up to the ring length and stopping at a match; a miss
// stores it as a new share. Then one result word per share (or one if none)
// is driven. One item is in work at a time. Configuration is written through
// wr_en / wr_index / wr_data; the user must write it only while idle, as the
// block itself does not enforce this. Reset (rst, synchronous) restores the
// register defaults and clears slot history and ring through valid bits at
// once, with no sweep, plus ring pointer and highest nonce; a restart item
// clears the same state, but not the registers, as it is taken.
module nonce_result_filter_top
  import nrf_pkg::*;
#(
  parameter int MAX_SLOTS  = MaxSlotsDef,
  parameter int MAX_GOLDEN = MaxGoldenDef,
  parameter int RING_DEPTH = RingDepthDef
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                restart,
  input  logic [SlotW-1:0]    slot,
  input  logic [NonceW-1:0]   slot_nonce,
  input  logic                hash_ok,
  input  logic [NonceW-1:0]   golden_a,
  input  logic [NonceW-1:0]   golden_b,
  input  logic [NonceW-1:0]   golden_c,
  input  logic [NonceW-1:0]   golden_d,
  input  logic                wr_en,
  input  logic [CfgIdxW-1:0]  wr_index,
  input  logic [CfgDataW-1:0] wr_data,
  output logic                done,
  output logic                share_valid,
  output logic [NonceW-1:0]   share_nonce,
  output logic                overflow,
  output logic                hw_error,
  output logic [NonceW-1:0]   highest_nonce,
  output logic                last
);

  localparam int HistIdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int PtrW     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int LenW     = $clog2(RING_DEPTH + 1);
  localparam int RawLenW  = 9;

  // configuration registers
  logic [SlotsCfgW-1:0] slots_in_use;
  logic [ExtraCfgW-1:0] extra_solutions;

  // memories and their valid bits
  logic [NonceW-1:0] hist_mem [MAX_SLOTS];
  logic [NonceW-1:0] ring_mem [RING_DEPTH];
  logic [MAX_SLOTS-1:0]  hist_ok;
  logic [RING_DEPTH-1:0] ring_ok;
  logic [NonceW-1:0] hist_rdata;
  logic [NonceW-1:0] ring_rdata;

  // run state
  logic [PtrW-1:0]   ring_pointer;
  logic [NonceW-1:0] highest_seen;

  // sequencer
  state_t state;
  logic [HistIdxW-1:0]   slot_q;
  logic [NonceW-1:0]     cnt_q;
  logic                  ok_q;
  logic                  slot_err_q;
  logic [NonceW-1:0]     gold_q [GoldenPorts];
  logic [LenW-1:0]       len_q;
  logic [GoldenCntW-1:0] ng_q;
  logic [GoldenCntW-1:0] gidx;
  logic [NonceW-1:0]     cur_g;
  logic [LenW-1:0]       issue_cnt;
  logic                  rd_vld;
  logic [PtrW-1:0]       rd_idx;
  logic                  ovf_q;
  logic                  err_q;
  logic [NonceW-1:0]     share_buf [GoldenPorts];
  logic [GoldenCntW-1:0] nshare;
  logic [GoldenCntW-1:0] emit_idx;

  // ring length, golden count and slot check from the registers
  logic [RawLenW-1:0]    raw_len;
  logic [LenW-1:0]       len_now;
  logic [GoldenCntW-1:0] ng_raw;
  logic [GoldenCntW-1:0] ng_now;
  logic                  slot_bad;

  always_comb begin
    raw_len = RawLenW'(slots_in_use) * (RawLenW'(extra_solutions) + RawLenW'(1));
    raw_len = raw_len << 1;
    if (raw_len > RawLenW'(RING_DEPTH)) begin
      len_now = LenW'(RING_DEPTH);
    end else if (raw_len == '0) begin
      len_now = LenW'(1);
    end else begin
      len_now = raw_len[LenW-1:0];
    end
    ng_raw = GoldenCntW'(extra_solutions) + GoldenCntW'(1);
    ng_now = (ng_raw > GoldenCntW'(MAX_GOLDEN)) ? GoldenCntW'(MAX_GOLDEN) : ng_raw;
    slot_bad = ((SlotsCfgW+1)'(slot) >= (SlotsCfgW+1)'(slots_in_use)) ||
               ((SlotsCfgW+1)'(slot) >= (SlotsCfgW+1)'(MAX_SLOTS));
  end

  // history check terms
  logic [NonceW-1:0] hist_val;
  logic              hist_drop;

  always_comb begin
    hist_val  = hist_ok[slot_q] ? hist_rdata : '0;
    hist_drop = cnt_q[30:4] < hist_val[30:4];
  end

  // ring scan hit and store pointer
  logic           scan_hit;
  logic           scan_end;
  logic [LenW-1:0] ptr_eff;
  logic [LenW-1:0] ptr_inc;

  always_comb begin
    scan_hit = rd_vld && ring_ok[rd_idx] && (ring_rdata == cur_g);
    scan_end = (issue_cnt == len_q) && !rd_vld;
    ptr_eff  = (LenW'(ring_pointer) >= len_q) ? '0 : LenW'(ring_pointer);
    ptr_inc  = ptr_eff + LenW'(1);
    if (ptr_inc >= len_q) begin
      ptr_inc = '0;
    end
  end

  // golden select
  logic [NonceW-1:0] sel_g;

  always_comb begin
    sel_g = gold_q[gidx[GoldenIdxW-1:0]];
  end

  logic emit_last;

  always_comb begin
    emit_last = (nshare == '0) || (emit_idx == nshare - GoldenCntW'(1));
  end

  assign busy = (state != S_IDLE);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      slots_in_use    <= SlotsCfgW'(1);
      extra_solutions <= '0;
      hist_ok         <= '0;
      ring_ok         <= '0;
      ring_pointer    <= '0;
      highest_seen    <= '0;
      done            <= 1'b0;
      rd_vld          <= 1'b0;
      issue_cnt       <= '0;
      gidx            <= '0;
      nshare          <= '0;
      emit_idx        <= '0;
    end else begin
      // result strobe follows the emit state
      done <= (state == S_EMIT);
      // register writes
      if (wr_en) begin
        unique case (wr_index)
          RegSlotsInUse:    slots_in_use    <= wr_data[SlotsCfgW-1:0];
          RegExtraSolution: extra_solutions <= wr_data[ExtraCfgW-1:0];
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (restart) begin
              hist_ok      <= '0;
              ring_ok      <= '0;
              ring_pointer <= '0;
              highest_seen <= '0;
            end
            state <= S_HIST;
          end
        end
        S_HIST: begin
          gidx   <= '0;
          nshare <= '0;
          if (slot_err_q) begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end else begin
            if (cnt_q > highest_seen) begin
              highest_seen <= cnt_q;
            end
            if (!hist_drop) begin
              hist_ok[slot_q] <= 1'b1;
            end
            if (!ok_q) begin
              emit_idx <= '0;
              state    <= S_EMIT;
            end else begin
              state <= S_NEXT;
            end
          end
        end
        S_NEXT: begin
          if (gidx == ng_q) begin
            emit_idx <= '0;
            state    <= S_EMIT;
          end else if (sel_g == '0) begin
            gidx <= gidx + GoldenCntW'(1);
          end else begin
            issue_cnt <= '0;
            rd_vld    <= 1'b0;
            state     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (issue_cnt != len_q) begin
            issue_cnt <= issue_cnt + LenW'(1);
          end
          rd_vld <= !scan_hit && (issue_cnt != len_q);
          if (scan_hit) begin
            gidx   <= gidx + GoldenCntW'(1);
            state  <= S_NEXT;
          end else if (scan_end) begin
            state <= S_STORE;
          end
        end
        S_STORE: begin
          ring_ok[ptr_eff[PtrW-1:0]] <= 1'b1;
          ring_pointer <= ptr_inc[PtrW-1:0];
          nshare       <= nshare + GoldenCntW'(1);
          gidx         <= gidx + GoldenCntW'(1);
          state        <= S_NEXT;
        end
        S_EMIT: begin
          emit_idx <= emit_idx + GoldenCntW'(1);
          if (emit_last) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload, memories and result word
  always_ff @(posedge clk) begin
    // history memory: read on accept, write back in the check cycle
    if (state == S_IDLE && start) begin
      hist_rdata <= hist_mem[HistIdxW'(slot)];
      slot_q     <= HistIdxW'(slot);
      cnt_q      <= slot_nonce;
      ok_q       <= hash_ok;
      slot_err_q <= slot_bad;
      gold_q[0]  <= golden_a;
      gold_q[1]  <= golden_b;
      gold_q[2]  <= golden_c;
      gold_q[3]  <= golden_d;
      len_q      <= len_now;
      ng_q       <= ng_now;
    end
    if (state == S_HIST) begin
      ovf_q <= !slot_err_q && hist_drop;
      err_q <= slot_err_q || !ok_q;
      if (!slot_err_q && !hist_drop) begin
        hist_mem[slot_q] <= cnt_q;
      end
    end
    if (state == S_NEXT) begin
      cur_g <= sel_g;
    end
    // ring memory: one read per scan cycle, write on store
    if (state == S_SCAN) begin
      ring_rdata <= ring_mem[issue_cnt[PtrW-1:0]];
      rd_idx     <= issue_cnt[PtrW-1:0];
    end
    if (state == S_STORE) begin
      ring_mem[ptr_eff[PtrW-1:0]] <= cur_g;
      share_buf[nshare[GoldenIdxW-1:0]] <= cur_g;
    end
    // result word
    if (state == S_EMIT) begin
      share_valid   <= (nshare != '0);
      share_nonce   <= (nshare != '0) ? share_buf[emit_idx[GoldenIdxW-1:0]] : '0;
      overflow      <= ovf_q;
      hw_error      <= err_q;
      highest_nonce <= highest_seen;
      last          <= emit_last;
    end
  end

endmodule
